### hdl/cmacc_pkg.sv
// ----------------------------------------------------------------------------
// cmacc_pkg
// Types, constants and saturating adders shared by the colocalization
// moment accumulator.
// ----------------------------------------------------------------------------
package cmacc_pkg;

  localparam int unsigned LOG2_MAX_PIXELS = 24;
  localparam int unsigned PIX_W           = 8;
  localparam int unsigned COUNT_W         = 25;
  localparam int unsigned OUT_TDATA_W     = 312;

  // pixel counter bound, clipped to the counter width
  localparam logic [COUNT_W-1:0] COUNT_LIMIT =
      (LOG2_MAX_PIXELS >= COUNT_W) ? {COUNT_W{1'b1}} :
                                     COUNT_W'(64'd1 << LOG2_MAX_PIXELS);

  localparam logic [PIX_W-1:0] MIN_RESET = '1;

  typedef struct packed {
    logic             last;
    logic             count_en;
    logic [PIX_W-1:0] y;
    logic [PIX_W-1:0] x;
  } pix_t;

  // first member is the top bit, so fields are listed from the high end
  typedef struct packed {
    logic [6:0]         pad;
    logic [PIX_W-1:0]   y_min;
    logic [PIX_W-1:0]   y_max;
    logic [PIX_W-1:0]   x_min;
    logic [PIX_W-1:0]   x_max;
    logic [31:0]        coloc_sum_y;
    logic [31:0]        coloc_sum_x;
    logic [COUNT_W-1:0] pixel_total;
    logic [39:0]        total_yy;
    logic [39:0]        total_xx;
    logic [39:0]        total_xy;
    logic [31:0]        total_y;
    logic [31:0]        total_x;
  } result_t;

  function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [PIX_W-1:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {25'd0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic logic [39:0] sat_add40(input logic [39:0] a, input logic [15:0] b);
    logic [40:0] s;
    s = {1'b0, a} + {25'd0, b};
    return s[40] ? 40'hFF_FFFF_FFFF : s[39:0];
  endfunction

endpackage

### hdl/cmacc_in_stage.sv
// ----------------------------------------------------------------------------
// cmacc_in_stage
// Input register for one pixel pair; hands the word on, but holds a
// last pixel until the result register is free.
// ----------------------------------------------------------------------------
module cmacc_in_stage
  import cmacc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  pix_t in_pix_i,
  output logic in_ready_o,
  input  logic out_free_i,
  output pix_t pix_o,
  output logic advance_o
);

  logic valid_q, valid_d;
  pix_t pix_q, pix_d;
  logic accept;

  assign advance_o  = valid_q & (~pix_q.last | out_free_i);
  assign in_ready_o = ~valid_q | advance_o;
  assign accept     = in_valid_i & in_ready_o;
  assign pix_o      = pix_q;

  always_comb begin
    valid_d = valid_q;
    pix_d   = pix_q;
    if (accept) begin
      valid_d = 1'b1;
      pix_d   = in_pix_i;
    end else if (advance_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pix_q <= pix_d;
  end

endmodule

### hdl/cmacc_accum.sv
// ----------------------------------------------------------------------------
// cmacc_accum
// Moment accumulators: products, saturating sums, pixel count and
// per-channel extremes, cleared after the last pixel of a frame.
// ----------------------------------------------------------------------------
module cmacc_accum
  import cmacc_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  pix_t    pix_i,
  input  logic    advance_i,
  output result_t total_o
);

  result_t acc_q, acc_d, upd, clr;
  logic [15:0] prod_xy, prod_xx, prod_yy;

  assign prod_xy = 16'(pix_i.x) * 16'(pix_i.y);
  assign prod_xx = 16'(pix_i.x) * 16'(pix_i.x);
  assign prod_yy = 16'(pix_i.y) * 16'(pix_i.y);

  always_comb begin
    clr       = '0;
    clr.x_min = MIN_RESET;
    clr.y_min = MIN_RESET;
  end

  always_comb begin
    upd          = acc_q;
    upd.pad      = '0;
    upd.total_x  = sat_add32(acc_q.total_x, pix_i.x);
    upd.total_y  = sat_add32(acc_q.total_y, pix_i.y);
    upd.total_xy = sat_add40(acc_q.total_xy, prod_xy);
    upd.total_xx = sat_add40(acc_q.total_xx, prod_xx);
    upd.total_yy = sat_add40(acc_q.total_yy, prod_yy);
    if (pix_i.count_en && (acc_q.pixel_total < COUNT_LIMIT)) begin
      upd.pixel_total = acc_q.pixel_total + COUNT_W'(1);
    end
    if (pix_i.y != '0) begin
      upd.coloc_sum_x = sat_add32(acc_q.coloc_sum_x, pix_i.x);
    end
    if (pix_i.x != '0) begin
      upd.coloc_sum_y = sat_add32(acc_q.coloc_sum_y, pix_i.y);
    end
    if (pix_i.x > acc_q.x_max) upd.x_max = pix_i.x;
    if (pix_i.x < acc_q.x_min) upd.x_min = pix_i.x;
    if (pix_i.y > acc_q.y_max) upd.y_max = pix_i.y;
    if (pix_i.y < acc_q.y_min) upd.y_min = pix_i.y;
  end

  assign total_o = upd;

  always_comb begin
    acc_d = acc_q;
    if (advance_i) begin
      acc_d = pix_i.last ? clr : upd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= clr;
    end else begin
      acc_q <= acc_d;
    end
  end

endmodule

### hdl/cmacc_out_reg.sv
// ----------------------------------------------------------------------------
// cmacc_out_reg
// Result register holding one frame's totals until the sink takes them.
// ----------------------------------------------------------------------------
module cmacc_out_reg
  import cmacc_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  result_t data_i,
  output logic    free_o,
  output logic    valid_o,
  input  logic    ready_i,
  output result_t data_o
);

  logic    valid_q, valid_d;
  result_t data_q, data_d;

  assign free_o  = ~valid_q | ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (load_i) begin
      valid_d = 1'b1;
      data_d  = data_i;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

endmodule

### hdl/colocalization_moment_accumulator_top.sv
// ----------------------------------------------------------------------------
// colocalization_moment_accumulator_top
// Accumulates Pearson and Manders moments of two-channel pixel pairs and
// emits one word of frame totals on the last pixel of each frame.
//
//   channel   dir  payload
//   s_axis    in   tdata = x, y; tlast = frame end
//   m_axis    out  tdata = all frame totals
//   cfg       in   ignore_zero write
//
// one pixel word accepted per cycle except in the stall below; a frame's
// totals pass the input register, then the result register, before
// they are offered; the only stall: a last pixel waits in the input
// register while the previous frame's result is still held by the sink
// reset clears the accumulators, the mins to 255, and ignore_zero to 1
// ----------------------------------------------------------------------------
module colocalization_moment_accumulator_top
  import cmacc_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_wr_en_i,
  input  logic                   cfg_wr_data_i,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // first_channel[7:0], second_channel[15:8]
  input  logic [15:0]            s_axis_tdata_i,
  input  logic                   s_axis_tlast_i,
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // total_x, total_y, total_xy, total_xx, total_yy, pixel_total,
  // coloc_sum_x, coloc_sum_y, x_max, x_min, y_max, y_min, zero pad
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o
);

  logic    ignore_zero_q;
  pix_t    in_pix, stage_pix;
  logic    advance, out_free, out_load;
  result_t total, out_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ignore_zero_q <= 1'b1;
    end else if (cfg_wr_en_i) begin
      ignore_zero_q <= cfg_wr_data_i;
    end
  end

  always_comb begin
    in_pix.x        = s_axis_tdata_i[PIX_W-1:0];
    in_pix.y        = s_axis_tdata_i[2*PIX_W-1:PIX_W];
    in_pix.last     = s_axis_tlast_i;
    in_pix.count_en = ~ignore_zero_q | (s_axis_tdata_i != '0);
  end

  cmacc_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_pix_i   (in_pix),
    .in_ready_o (s_axis_tready_o),
    .out_free_i (out_free),
    .pix_o      (stage_pix),
    .advance_o  (advance)
  );

  cmacc_accum u_accum (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .pix_i     (stage_pix),
    .advance_i (advance),
    .total_o   (total)
  );

  assign out_load = advance & stage_pix.last;

  cmacc_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (out_load),
    .data_i  (total),
    .free_o  (out_free),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .data_o  (out_data)
  );

  assign m_axis_tdata_o = out_data;

  a_last_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> m_axis_tvalid_o)
    else $error("frame end did not produce a result word");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (out_data.pixel_total <= COUNT_LIMIT))
    else $error("pixel count above bound");

  a_extremes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (out_data.x_min <= out_data.x_max) &&
                        (out_data.y_min <= out_data.y_max))
    else $error("min above max in result word");

  a_coloc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (out_data.coloc_sum_x <= out_data.total_x) &&
                        (out_data.coloc_sum_y <= out_data.total_y))
    else $error("colocalized sum above total");

endmodule
